### src/plcs_pkg.sv
// Package of the piecewise-linear curve sampler: field widths, register
// indexes, reset values and the side-band struct that travels down the pipe.
// No dependencies.
package plcs_pkg;

  localparam int unsigned PLCS_MAX_POINTS = 8;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned SEG_W      = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PROD_W     = 2 * VAL_W;

  // The divider resolves this many quotient bits per pipeline stage.
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_STAGES    = VAL_W / DIV_STEP_BITS;

  localparam logic [VAL_W-1:0] FULL_SCALE = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_RESET  = CNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_PAIR_01     = 3'd1,
    REG_PAIR_23     = 3'd2,
    REG_PAIR_45     = 3'd3,
    REG_PAIR_67     = 3'd4
  } plcs_reg_e;

  // Per-request information that bypasses the arithmetic. When direct is set,
  // base is the final value; otherwise base is the left-hand y and neg tells
  // whether the scaled step is subtracted.
  typedef struct packed {
    logic             direct;
    logic [VAL_W-1:0] base;
    logic [SEG_W-1:0] seg;
    logic             neg;
  } plcs_side_t;

endpackage

### src/piecewise_linear_curve_sampler.sv
// Piecewise-linear curve sampler: one position request per cycle in, one curve
// value per cycle out when the output is not stalled. The pipeline is built
// from two search stages, one multiply stage, the four-stage restoring
// divider (four quotient bits per stage) and the output register. Points are
// written through the configuration port, which is always ready and takes one
// write per cycle; writes belong between requests, when the pipeline is empty.
// Points must be written in ascending x. Depends on plcs_pkg, plcs_locate,
// plcs_scale and plcs_divider.
module piecewise_linear_curve_sampler #(
  parameter int unsigned MAX_POINTS = plcs_pkg::PLCS_MAX_POINTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [plcs_pkg::VAL_W-1:0]        position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [plcs_pkg::VAL_W-1:0]        curve_value_o,
  output logic [plcs_pkg::SEG_W-1:0]        segment_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [plcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import plcs_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] count_q;
  logic [VAL_W-1:0] x_q [MAX_POINTS];
  logic [VAL_W-1:0] y_q [MAX_POINTS];
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_we && cfg_index_i == REG_POINT_COUNT) begin
      count_q <= cfg_data_i[CNT_W-1:0];
    end
  end

  // Each pair register holds two points; the lower point sits in the low half.
  for (genvar p = 0; p < MAX_POINTS; p++) begin : g_point
    localparam int unsigned LSB = 2 * VAL_W * (p & 1);
    logic sel;

    assign sel = cfg_we &&
                 (cfg_index_i == CFG_IDX_W'(REG_PAIR_01) + CFG_IDX_W'(p >> 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        x_q[p] <= (p == 1) ? FULL_SCALE : '0;
        y_q[p] <= (p == 0) ? FULL_SCALE : '0;
      end else if (sel) begin
        x_q[p] <= cfg_data_i[LSB +: VAL_W];
        y_q[p] <= cfg_data_i[LSB + VAL_W +: VAL_W];
      end
    end
  end

  // Datapath.
  logic              loc_valid, loc_ready;
  plcs_side_t        loc_side;
  logic [VAL_W-1:0]  loc_mag, loc_dt, loc_span;

  logic              mul_valid, mul_ready;
  plcs_side_t        mul_side;
  logic [PROD_W-1:0] mul_prod;
  logic [VAL_W-1:0]  mul_span;

  logic              div_valid, div_ready;
  plcs_side_t        div_side;
  logic [VAL_W-1:0]  div_quo;

  plcs_locate #(
    .MAX_POINTS(MAX_POINTS)
  ) u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .position_i (position_i),
    .count_i    (count_q),
    .x_i        (x_q),
    .y_i        (y_q),
    .out_valid_o(loc_valid),
    .out_ready_i(loc_ready),
    .side_o     (loc_side),
    .mag_o      (loc_mag),
    .dt_o       (loc_dt),
    .span_o     (loc_span)
  );

  plcs_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (loc_valid),
    .in_ready_o (loc_ready),
    .side_i     (loc_side),
    .mag_i      (loc_mag),
    .dt_i       (loc_dt),
    .span_i     (loc_span),
    .out_valid_o(mul_valid),
    .out_ready_i(mul_ready),
    .side_o     (mul_side),
    .prod_o     (mul_prod),
    .span_o     (mul_span)
  );

  plcs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mul_valid),
    .in_ready_o (mul_ready),
    .side_i     (mul_side),
    .prod_i     (mul_prod),
    .span_i     (mul_span),
    .out_valid_o(div_valid),
    .out_ready_i(div_ready),
    .side_o     (div_side),
    .quo_o      (div_quo)
  );

  // Output register. The interpolated step never exceeds the y difference, so
  // the sum stays inside the range of the two end values.
  logic             out_valid_q;
  logic [VAL_W-1:0] value_q, value_d;
  logic [SEG_W-1:0] seg_q;

  always_comb begin
    if (div_side.direct) begin
      value_d = div_side.base;
    end else if (div_side.neg) begin
      value_d = div_side.base - div_quo;
    end else begin
      value_d = div_side.base + div_quo;
    end
  end

  assign div_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      value_q <= value_d;
      seg_q   <= div_side.seg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign curve_value_o   = value_q;
  assign segment_index_o = seg_q;

  // An empty output register must never hold back new requests.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready although the output stage is empty");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (segment_index_o <= SEG_W'(MAX_POINTS - 1)))
    else $error("segment index beyond the last control point");

  // The divided step must not carry the result below zero or above full scale.
  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && !div_side.direct) |->
      ((div_side.neg && (div_quo <= div_side.base)) ||
       (!div_side.neg && (({1'b0, div_side.base} + {1'b0, div_quo}) <= {1'b0, FULL_SCALE}))))
    else $error("interpolation step leaves the segment's value range");

endmodule

### src/plcs_locate.sv
// Segment search of the curve sampler: two pipeline stages that compare the
// position against every control point and then pick out the segment operands.
// Depends on plcs_pkg.
module plcs_locate #(
  parameter int unsigned MAX_POINTS = plcs_pkg::PLCS_MAX_POINTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [plcs_pkg::VAL_W-1:0]    position_i,
  input  logic [plcs_pkg::CNT_W-1:0]    count_i,
  input  logic [plcs_pkg::VAL_W-1:0]    x_i [MAX_POINTS],
  input  logic [plcs_pkg::VAL_W-1:0]    y_i [MAX_POINTS],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output plcs_pkg::plcs_side_t          side_o,
  output logic [plcs_pkg::VAL_W-1:0]    mag_o,
  output logic [plcs_pkg::VAL_W-1:0]    dt_o,
  output logic [plcs_pkg::VAL_W-1:0]    span_o
);
  import plcs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);

  // Stage A: compares.
  logic                  a_valid_q;
  logic [VAL_W-1:0]      a_pos_q;
  logic                  a_few_q, a_first_q, a_after_q;
  logic [IW-1:0]         a_last_q;
  logic [MAX_POINTS-1:0] a_hit_q;

  logic [CNT_W-1:0]      n_eff;
  logic                  few;
  logic [IW-1:0]         last_idx;
  logic [MAX_POINTS-1:0] hit;
  logic                  a_ready, b_ready;

  always_comb begin
    n_eff    = (count_i > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_i;
    few      = (n_eff < CNT_W'(2));
    last_idx = few ? '0 : IW'(n_eff - CNT_W'(1));
    for (int i = 0; i < MAX_POINTS; i++) begin
      hit[i] = (i != 0) && (CNT_W'(i) < n_eff) && (position_i <= x_i[i]);
    end
  end

  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_pos_q   <= position_i;
      a_few_q   <= few;
      a_first_q <= (position_i <= x_i[0]);
      a_after_q <= (position_i >= x_i[last_idx]);
      a_last_q  <= last_idx;
      a_hit_q   <= hit;
    end
  end

  // Stage B: the first hit is the right-hand point of the segment.
  logic             b_valid_q;
  plcs_side_t       b_side_q;
  logic [VAL_W-1:0] b_mag_q, b_dt_q, b_span_q;

  logic [IW-1:0]    idx, prev_idx;
  logic [VAL_W-1:0] xa, xb, ya, yb;
  plcs_side_t       side_d;

  always_comb begin
    idx = IW'(1);
    for (int i = MAX_POINTS - 1; i >= 1; i--) begin
      if (a_hit_q[i]) begin
        idx = IW'(i);
      end
    end
    prev_idx = idx - IW'(1);
    xa = x_i[prev_idx];
    xb = x_i[idx];
    ya = y_i[prev_idx];
    yb = y_i[idx];

    side_d.neg = (yb < ya);
    if (a_few_q) begin
      side_d.direct = 1'b1;
      side_d.base   = FULL_SCALE;
      side_d.seg    = '0;
    end else if (a_first_q) begin
      side_d.direct = 1'b1;
      side_d.base   = y_i[0];
      side_d.seg    = '0;
    end else if (a_after_q) begin
      side_d.direct = 1'b1;
      side_d.base   = y_i[a_last_q];
      side_d.seg    = SEG_W'(a_last_q);
    end else if (xb <= xa) begin
      // A segment of zero or negative width takes the right-hand y.
      side_d.direct = 1'b1;
      side_d.base   = yb;
      side_d.seg    = SEG_W'(idx);
    end else begin
      side_d.direct = 1'b0;
      side_d.base   = ya;
      side_d.seg    = SEG_W'(idx);
    end
  end

  assign b_ready = !b_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_side_q <= side_d;
      b_mag_q  <= side_d.neg ? (ya - yb) : (yb - ya);
      b_dt_q   <= a_pos_q - xa;
      b_span_q <= xb - xa;
    end
  end

  assign out_valid_o = b_valid_q;
  assign side_o      = b_side_q;
  assign mag_o       = b_mag_q;
  assign dt_o        = b_dt_q;
  assign span_o      = b_span_q;

endmodule

### src/plcs_scale.sv
// Multiply stage of the curve sampler: forms the exact product of the y step
// magnitude and the offset into the segment. Depends on plcs_pkg.
module plcs_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  plcs_pkg::plcs_side_t          side_i,
  input  logic [plcs_pkg::VAL_W-1:0]    mag_i,
  input  logic [plcs_pkg::VAL_W-1:0]    dt_i,
  input  logic [plcs_pkg::VAL_W-1:0]    span_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output plcs_pkg::plcs_side_t          side_o,
  output logic [plcs_pkg::PROD_W-1:0]   prod_o,
  output logic [plcs_pkg::VAL_W-1:0]    span_o
);
  import plcs_pkg::*;

  logic              valid_q;
  plcs_side_t        side_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  span_q;
  logic              ready;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      side_q <= side_i;
      prod_q <= PROD_W'(mag_i) * PROD_W'(dt_i);
      span_q <= span_i;
    end
  end

  assign out_valid_o = valid_q;
  assign side_o      = side_q;
  assign prod_o      = prod_q;
  assign span_o      = span_q;

endmodule

### src/plcs_divider.sv
// Pipelined restoring divider of the curve sampler: divides the product by
// the segment width, four quotient bits per stage. Depends on plcs_pkg.
module plcs_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  plcs_pkg::plcs_side_t          side_i,
  input  logic [plcs_pkg::PROD_W-1:0]   prod_i,
  input  logic [plcs_pkg::VAL_W-1:0]    span_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output plcs_pkg::plcs_side_t          side_o,
  output logic [plcs_pkg::VAL_W-1:0]    quo_o
);
  import plcs_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] quo;
  } plcs_div_t;

  // The quotient is known to fit in VAL_W bits, so the upper product half is
  // already below the divisor and serves as the starting remainder.
  function automatic plcs_div_t div_steps(plcs_div_t cur, logic [VAL_W-1:0] span);
    logic [VAL_W:0] trial;
    plcs_div_t      nxt;
    nxt = cur;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial   = {nxt.rem, nxt.num[VAL_W-1]};
      nxt.num = {nxt.num[VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, span}) begin
        nxt.rem = VAL_W'(trial - {1'b0, span});
        nxt.quo = {nxt.quo[VAL_W-2:0], 1'b1};
      end else begin
        nxt.rem = trial[VAL_W-1:0];
        nxt.quo = {nxt.quo[VAL_W-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  logic             valid_q [DIV_STAGES];
  plcs_side_t       side_q  [DIV_STAGES];
  plcs_div_t        div_q   [DIV_STAGES];
  logic [VAL_W-1:0] span_q  [DIV_STAGES];
  logic             ready   [DIV_STAGES];

  plcs_div_t        div_init;

  assign div_init.rem = prod_i[PROD_W-1:VAL_W];
  assign div_init.num = prod_i[VAL_W-1:0];
  assign div_init.quo = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             prev_valid;
    plcs_side_t       prev_side;
    plcs_div_t        prev_div;
    logic [VAL_W-1:0] prev_span;
    logic             next_ready;

    if (s == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign prev_side  = side_i;
      assign prev_div   = div_init;
      assign prev_span  = span_i;
    end else begin : g_chain
      assign prev_valid = valid_q[s-1];
      assign prev_side  = side_q[s-1];
      assign prev_div   = div_q[s-1];
      assign prev_span  = span_q[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_tail
      assign next_ready = out_ready_i;
    end else begin : g_mid
      assign next_ready = ready[s+1];
    end

    assign ready[s] = !valid_q[s] || next_ready;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ready[s]) begin
        valid_q[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[s] && prev_valid) begin
        side_q[s] <= prev_side;
        div_q[s]  <= div_steps(prev_div, prev_span);
        span_q[s] <= prev_span;
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign side_o      = side_q[DIV_STAGES-1];
  assign quo_o       = div_q[DIV_STAGES-1].quo;

endmodule

### sim/tb_piecewise_linear_curve_sampler.sv
// Testbench of the piecewise-linear curve sampler. It drives position requests
// and register writes, and checks every result against a model of the curve or
// a listed value. Depends on plcs_pkg and piecewise_linear_curve_sampler.
module tb_piecewise_linear_curve_sampler;
  import plcs_pkg::*;

  localparam int unsigned PIPE_LATENCY   = 8;
  localparam int unsigned SETTLE_CYCLES  = PIPE_LATENCY + 4;
  localparam int unsigned RANDOM_SAMPLES = 1750;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned MAX_REPORTS    = 20;
  localparam int unsigned DIRECTED_COUNT = 44;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNMAPPED = 3'd5;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SEG_W-1:0] seg;
  } curve_sample_t;

  typedef struct packed {
    logic [VAL_W-1:0] pos;
    curve_sample_t    want;
  } pending_sample_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_SAMPLE_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [VAL_W-1:0]      pos;
    curve_sample_t         known;
  } directed_row_t;

  // Point pairs are packed as {y_odd, x_odd, y_even, x_even}.
  localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    // Reset curve: falls from full scale at x=0 to zero at x=1.0.
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h0000, '{16'hFFFF, 3'd0}},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFF, '{16'h0000, 3'd1}},
    '{ROW_SAMPLE,       '0, '0, 16'h8000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'h0001, '{16'h0000, 3'd0}},
    // Too few points gives full scale.
    '{ROW_WRITE, REG_POINT_COUNT, 64'd0, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h1234, '{16'hFFFF, 3'd0}},
    '{ROW_WRITE, REG_POINT_COUNT, 64'd1, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFF, '{16'hFFFF, 3'd0}},
    // Eight points with a zero-width segment, then a count above the maximum.
    '{ROW_WRITE, REG_PAIR_01, 64'hFFFF_4000_0000_1000, '0, '0},
    '{ROW_WRITE, REG_PAIR_23, 64'h8000_8000_2000_4000, '0, '0},
    '{ROW_WRITE, REG_PAIR_45, 64'hFFFF_E000_1000_C000, '0, '0},
    '{ROW_WRITE, REG_PAIR_67, 64'h1234_FFFF_0000_F000, '0, '0},
    '{ROW_WRITE, REG_POINT_COUNT, 64'd15, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h0000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h1000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFF, '{16'h1234, 3'd7}},
    '{ROW_SAMPLE,       '0, '0, 16'h4000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'h2000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'h6000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'hC001, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'hFFFE, '{16'h0000, 3'd0}},
    // Three points: clamped after the last one in use.
    '{ROW_WRITE, REG_POINT_COUNT, 64'd3, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h5000, '{16'h2000, 3'd2}},
    '{ROW_SAMPLE,       '0, '0, 16'h3FFF, '{16'h0000, 3'd0}},
    // A write to an unmapped index must leave the curve alone.
    '{ROW_WRITE, CFG_INDEX_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_SAMPLE,       '0, '0, 16'h3000, '{16'h0000, 3'd0}},
    // Unsorted points.
    '{ROW_WRITE, REG_PAIR_01, 64'hF000_9000_0100_2000, '0, '0},
    '{ROW_WRITE, REG_PAIR_23, 64'h0000_F000_FFFF_5000, '0, '0},
    '{ROW_WRITE, REG_POINT_COUNT, 64'd4, '0, '0},
    '{ROW_SAMPLE,       '0, '0, 16'h8000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE,       '0, '0, 16'hA000, '{16'h0000, 3'd0}},
    // All points at full scale.
    '{ROW_WRITE, REG_PAIR_01, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_WRITE, REG_PAIR_23, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_WRITE, REG_PAIR_45, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_WRITE, REG_PAIR_67, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{ROW_WRITE, REG_POINT_COUNT, 64'd8, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFE, '{16'hFFFF, 3'd0}},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFF, '{16'hFFFF, 3'd0}},
    // All points at zero.
    '{ROW_WRITE, REG_PAIR_01, 64'd0, '0, '0},
    '{ROW_WRITE, REG_PAIR_23, 64'd0, '0, '0},
    '{ROW_WRITE, REG_PAIR_45, 64'd0, '0, '0},
    '{ROW_WRITE, REG_PAIR_67, 64'd0, '0, '0},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'h0000, '{16'h0000, 3'd0}},
    '{ROW_SAMPLE_KNOWN, '0, '0, 16'hFFFF, '{16'h0000, 3'd7}}
  };

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [VAL_W-1:0]      position      = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [VAL_W-1:0]      curve_value;
  logic [SEG_W-1:0]      segment_index;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Curve as the block should hold it.
  logic [CNT_W-1:0]      curve_count;
  logic [CFG_DATA_W-1:0] curve_pairs [4];

  pending_sample_t pending_samples [$];
  int unsigned     mismatches      = 0;
  int unsigned     samples_checked = 0;
  int unsigned     reg_writes      = 0;
  bit              quiet_phase     = 1'b0;
  bit              hold_output     = 1'b0;

  piecewise_linear_curve_sampler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .position_i      (position),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .curve_value_o   (curve_value),
    .segment_index_o (segment_index),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [VAL_W-1:0] point_x(input int unsigned i);
    return curve_pairs[i / 2][(i % 2) * 32 +: VAL_W];
  endfunction

  function automatic logic [VAL_W-1:0] point_y(input int unsigned i);
    return curve_pairs[i / 2][(i % 2) * 32 + 16 +: VAL_W];
  endfunction

  function automatic curve_sample_t curve_at(input logic [VAL_W-1:0] pos);
    int unsigned   n;
    int unsigned   last;
    int unsigned   i;
    bit            found;
    longint        xa, xb, ya, yb, span, dt, v;
    curve_sample_t r;
    n = (curve_count > PLCS_MAX_POINTS) ? PLCS_MAX_POINTS : curve_count;
    r.value = FULL_SCALE;
    r.seg   = '0;
    if (n >= 2) begin
      last = n - 1;
      if (pos <= point_x(0)) begin
        r.value = point_y(0);
      end else if (pos >= point_x(last)) begin
        r.value = point_y(last);
        r.seg   = SEG_W'(last);
      end else begin
        r.value = point_y(last);
        r.seg   = SEG_W'(last);
        found   = 1'b0;
        // First point at or beyond the position closes the segment.
        for (i = 1; i < n && !found; i++) begin
          if (pos <= point_x(i)) begin
            found = 1'b1;
            xa    = longint'(point_x(i - 1));
            xb    = longint'(point_x(i));
            ya    = longint'(point_y(i - 1));
            yb    = longint'(point_y(i));
            span  = xb - xa;
            r.seg = SEG_W'(i);
            if (span <= 0) begin
              r.value = VAL_W'(yb);
            end else begin
              dt = longint'(pos) - xa;
              v  = ya + ((yb - ya) * dt) / span;
              if (v < 0) v = 0;
              if (v > 65535) v = 65535;
              r.value = VAL_W'(v);
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [VAL_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return VAL_W'($urandom);
    // Land on a configured x or right next to it.
    if (r < 8) return point_x($urandom_range(0, 7)) + VAL_W'($urandom_range(0, 2)) - 16'd1;
    return $urandom_range(0, 1) ? FULL_SCALE : '0;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POINT_COUNT: curve_count = data[CNT_W-1:0];
      REG_PAIR_01:     curve_pairs[0] = data;
      REG_PAIR_23:     curve_pairs[1] = data;
      REG_PAIR_45:     curve_pairs[2] = data;
      REG_PAIR_67:     curve_pairs[3] = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_position(input logic [VAL_W-1:0] pos, input int unsigned gap,
                               input bit use_known, input curve_sample_t known);
    pending_sample_t entry;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entry.pos  = pos;
    entry.want = use_known ? known : curve_at(pos);
    pending_samples.push_back(entry);
    @(negedge clk);
  endtask

  task automatic settle_pipe();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_random_curve();
    logic [VAL_W-1:0] xs [8];
    logic [VAL_W-1:0] ys [8];
    logic [VAL_W-1:0] swap;
    logic [VAL_W-1:0] base;
    logic [CFG_DATA_W-1:0] count_word;
    int unsigned style, i, j;
    style = $urandom_range(0, 9);
    base  = VAL_W'($urandom);
    for (i = 0; i < 8; i++) begin
      xs[i] = VAL_W'($urandom);
      ys[i] = VAL_W'($urandom);
      if (style == 6) begin
        // Tightly packed x values give coincident and adjacent points.
        xs[i] = base + VAL_W'($urandom_range(0, 3));
      end else if (style >= 8) begin
        j = $urandom_range(0, 3);
        xs[i] = (j == 0) ? '0 : (j == 1) ? FULL_SCALE : xs[i];
        ys[i] = $urandom_range(0, 1) ? FULL_SCALE : '0;
      end
    end
    if (style != 7) begin
      for (i = 0; i < 8; i++) begin
        for (j = 0; j + 1 < 8 - i; j++) begin
          if (xs[j] > xs[j + 1]) begin
            swap      = xs[j];
            xs[j]     = xs[j + 1];
            xs[j + 1] = swap;
          end
        end
      end
    end
    count_word = {$urandom, $urandom};
    count_word[CNT_W-1:0] = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(2, 8))
                                                        : CNT_W'($urandom_range(0, 15));
    write_reg(REG_POINT_COUNT, count_word);
    write_reg(REG_PAIR_01, {ys[1], xs[1], ys[0], xs[0]});
    write_reg(REG_PAIR_23, {ys[3], xs[3], ys[2], xs[2]});
    write_reg(REG_PAIR_45, {ys[5], xs[5], ys[4], xs[4]});
    write_reg(REG_PAIR_67, {ys[7], xs[7], ys[6], xs[6]});
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(CFG_INDEX_UNMAPPED + $urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  always @(posedge clk) begin : result_check
    pending_sample_t got;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("unrequested result value %h segment %0d",
                                curve_value, segment_index));
      end else begin
        got = pending_samples.pop_front();
        samples_checked++;
        if (curve_value !== got.want.value)
          flag_mismatch($sformatf("position %h: value %h, wanted %h",
                                  got.pos, curve_value, got.want.value));
        if (segment_index !== got.want.seg)
          flag_mismatch($sformatf("position %h: segment %0d, wanted %0d",
                                  got.pos, segment_index, got.want.seg));
      end
    end
  end

  initial begin : receiver
    int unsigned r;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        // Long stall so the pipeline fills and backs up into the input.
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (quiet_phase) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat ((r < 96) ? $urandom_range(0, 2) : $urandom_range(6, 30)) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles_seen;
    cycles_seen = 0;
    while (cycles_seen < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_seen++;
    end
    $display("piecewise_linear_curve_sampler: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned   row, k, phase_len, phases, random_sent, gap;
    curve_sample_t none;
    none           = '0;
    phases         = 0;
    random_sent    = 0;
    curve_count    = CNT_RESET;
    curve_pairs[0] = 64'h0000_FFFF_FFFF_0000;
    curve_pairs[1] = '0;
    curve_pairs[2] = '0;
    curve_pairs[3] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < DIRECTED_COUNT; row++) begin
      case (DIRECTED_ROWS[row].kind)
        ROW_WRITE: begin
          settle_pipe();
          write_reg(DIRECTED_ROWS[row].idx, DIRECTED_ROWS[row].data);
        end
        ROW_SAMPLE: push_position(DIRECTED_ROWS[row].pos, pick_gap(), 1'b0, none);
        default: push_position(DIRECTED_ROWS[row].pos, pick_gap(), 1'b1,
                               DIRECTED_ROWS[row].known);
      endcase
    end

    while (random_sent < RANDOM_SAMPLES) begin
      settle_pipe();
      load_random_curve();
      quiet_phase = ($urandom_range(0, 4) == 0);
      phase_len   = $urandom_range(64, 128);
      for (k = 0; k < phase_len; k++) begin
        gap = pick_gap();
        if (phases == 1 && k == 20) hold_output = 1'b1;
        if (phases == 1 && k >= 20 && k < 60) gap = 0;
        // Sender pauses until every outstanding result is back.
        if (phases == 3 && k == phase_len / 2) settle_pipe();
        push_position(pick_position(), gap, 1'b0, none);
        random_sent++;
      end
      phases++;
    end
    settle_pipe();

    $display("Checked %0d curve samples across %0d register writes and %0d random curves.",
             samples_checked, reg_writes, phases);
    $display("Covered counts outside 2..8, unsorted and coincident points, and output stalls.");
    if (mismatches == 0) begin
      $display("piecewise_linear_curve_sampler: match");
    end else begin
      $display("piecewise_linear_curve_sampler: mismatch");
    end
    $finish;
  end

endmodule
